### sv/hfmf_pkg.sv
// Shared constants and types for the half-float to mixed-fraction decoder.
package hfmf_pkg;

	// binary16 layout
	localparam int unsigned HalfW   = 16;
	localparam int unsigned MantW   = 10;
	localparam int unsigned ExpW    = 5;
	localparam int unsigned SigW    = MantW + 1;
	localparam int unsigned HalfBias = 15;

	// result field widths
	localparam int unsigned ClassW = 2;
	localparam int unsigned IntW   = 16;
	localparam int unsigned NumW   = 24;
	localparam int unsigned DenW   = 25;

	// packed stream widths
	localparam int unsigned InDataW  = 16;
	localparam int unsigned OutBitsW = ClassW + 1 + IntW + NumW + DenW;
	localparam int unsigned OutDataW = ((OutBitsW + 7) / 8) * 8;

	// exponent codes
	localparam logic [ExpW-1:0] ExpAllOnes = 5'd31;
	localparam logic [ExpW-1:0] ExpZero    = 5'd0;
	// exponent at which the right shift reaches zero: bias + mantissa bits
	localparam logic [ExpW-1:0] ExpUnity   = 5'(HalfBias + MantW);
	// right shift for subnormals: mantissa bits + bias - 1
	localparam logic [4:0]      SubShift   = 5'(MantW + HalfBias - 1);

	// value class codes
	typedef enum logic [ClassW-1:0] {
		CLASS_FINITE  = 2'd0,
		CLASS_POS_INF = 2'd1,
		CLASS_NEG_INF = 2'd2,
		CLASS_NAN     = 2'd3
	} value_class_t;

endpackage

### sv/half_float_to_mixed_fraction_core.sv
// Pipelined decoder from a binary16 word to class, sign, integer part and reduced fraction.
// Each input transfer reaches the output port through the stage registers s1, s2, s3 and s4.
// Throughput: one word per cycle; the four register stages advance independently,
// so a bubble closes up and a stall on the output holds every stage in place.
// Stage depth is set by the barrel shifters in stages 2 and 4.
// Reset: arst_n low clears all stage valid bits at once; payload registers are not reset.
module half_float_to_mixed_fraction_core
	import hfmf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// s_tdata fields from bit 0 up: half_bits[15:0]
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,
	// m_tdata fields from bit 0 up: value_class[1:0], negative[2], integer_part[18:3],
	// numerator[42:19], denominator[67:43], zero fill[71:68]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata
);

	// stage load enables
	logic en_s1, en_s2, en_s3, en_s4;
	logic v_s1, v_s2, v_s3, v_s4;

	// stage 1 registers
	value_class_t      cls_s1;
	logic              neg_s1;
	logic [SigW-1:0]   sig_s1;
	logic              left_s1;
	logic [2:0]        lsh_s1;
	logic [4:0]        rsh_s1;

	// stage 2 registers
	value_class_t      cls_s2;
	logic              neg_s2;
	logic [IntW-1:0]   ipart_s2;
	logic [SigW-1:0]   fr_s2;
	logic [4:0]        k_s2;

	// stage 3 registers
	value_class_t      cls_s3;
	logic              neg_s3;
	logic [IntW-1:0]   ipart_s3;
	logic [SigW-1:0]   fr_s3;
	logic [4:0]        k_s3;
	logic [3:0]        tz_s3;

	// stage 4 registers, the output register
	value_class_t      cls_s4;
	logic              neg_s4;
	logic [IntW-1:0]   ipart_s4;
	logic [NumW-1:0]   num_s4;
	logic [DenW-1:0]   den_s4;

	// a stage loads when it is empty or its content moves on
	assign en_s4    = !v_s4 || m_tready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// stage 1: split the word, classify, pick the shift direction and amount
	logic              in_sign;
	logic [ExpW-1:0]   in_exp;
	logic [MantW-1:0]  in_mant;
	value_class_t      cls_d1;
	logic [SigW-1:0]   sig_d1;
	logic              left_d1;
	logic [2:0]        lsh_d1;
	logic [4:0]        rsh_d1;

	always_comb begin
		in_sign = s_tdata[HalfW-1];
		in_exp  = s_tdata[MantW +: ExpW];
		in_mant = s_tdata[MantW-1:0];
		cls_d1  = CLASS_FINITE;
		sig_d1  = {1'b1, in_mant};
		left_d1 = 1'b0;
		lsh_d1  = 3'd0;
		rsh_d1  = 5'd0;
		if (in_exp == ExpAllOnes) begin
			// infinities and NaN carry no magnitude
			sig_d1 = '0;
			if (in_mant != '0)
				cls_d1 = CLASS_NAN;
			else if (in_sign)
				cls_d1 = CLASS_NEG_INF;
			else
				cls_d1 = CLASS_POS_INF;
		end else if (in_exp == ExpZero) begin
			// subnormal: no hidden one, exponent 1 - bias
			sig_d1 = {1'b0, in_mant};
			rsh_d1 = SubShift;
		end else if (in_exp >= ExpUnity) begin
			left_d1 = 1'b1;
			lsh_d1  = 3'(in_exp - ExpUnity);
		end else begin
			rsh_d1 = ExpUnity - in_exp;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			cls_s1  <= cls_d1;
			neg_s1  <= in_sign;
			sig_s1  <= sig_d1;
			left_s1 <= left_d1;
			lsh_s1  <= lsh_d1;
			rsh_s1  <= rsh_d1;
		end
	end

	// stage 2: integer part by shifting, fraction bits by masking
	logic [IntW-1:0]  sig_ext;
	logic [DenW-1:0]  mask_w;
	logic [IntW-1:0]  ipart_d2;
	logic [SigW-1:0]  fr_d2;

	always_comb begin
		sig_ext = {{(IntW-SigW){1'b0}}, sig_s1};
		mask_w  = (DenW'(1) << rsh_s1) - DenW'(1);
		if (left_s1) begin
			ipart_d2 = sig_ext << lsh_s1;
			fr_d2    = '0;
		end else begin
			ipart_d2 = sig_ext >> rsh_s1;
			fr_d2    = sig_s1 & mask_w[SigW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			cls_s2   <= cls_s1;
			neg_s2   <= neg_s1;
			ipart_s2 <= ipart_d2;
			fr_s2    <= fr_d2;
			k_s2     <= rsh_s1;
		end
	end

	// stage 3: locate the lowest set bit of the fraction
	logic [3:0] tz_d3;

	always_comb begin
		tz_d3 = 4'd0;
		for (int i = SigW - 1; i >= 0; i--) begin
			if (fr_s2[i]) tz_d3 = 4'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			cls_s3   <= cls_s2;
			neg_s3   <= neg_s2;
			ipart_s3 <= ipart_s2;
			fr_s3    <= fr_s2;
			k_s3     <= k_s2;
			tz_s3    <= tz_d3;
		end
	end

	// stage 4: strip trailing zeros and form the power-of-two denominator
	logic [SigW-1:0] num_d4;
	logic [4:0]      dexp_d4;
	logic [DenW-1:0] den_d4;

	always_comb begin
		num_d4  = fr_s3 >> tz_s3;
		dexp_d4 = k_s3 - 5'(tz_s3);
		if (fr_s3 == '0)
			den_d4 = DenW'(1);
		else
			den_d4 = DenW'(1) << dexp_d4;
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			cls_s4   <= cls_s3;
			neg_s4   <= neg_s3;
			ipart_s4 <= ipart_s3;
			num_s4   <= {{(NumW-SigW){1'b0}}, num_d4};
			den_s4   <= den_d4;
		end
	end

	// pack the result
	assign m_tvalid = v_s4;
	assign m_tdata  = {{(OutDataW-OutBitsW){1'b0}}, den_s4, num_s4, ipart_s4, neg_s4, cls_s4};

endmodule

### sv/hfmf_checker.sv
// Port-level checker for the decoder, bound to the top level.
module hfmf_checker
	import hfmf_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OutDataW-1:0] m_tdata
);

	logic [ClassW-1:0] o_cls;
	logic [IntW-1:0]   o_int;
	logic [NumW-1:0]   o_num;
	logic [DenW-1:0]   o_den;

	assign o_cls = m_tdata[ClassW-1:0];
	assign o_int = m_tdata[ClassW+1 +: IntW];
	assign o_num = m_tdata[ClassW+1+IntW +: NumW];
	assign o_den = m_tdata[ClassW+1+IntW+NumW +: DenW];

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or dropped");

	// denominator is always a single power of two
	a_den_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot(o_den))
		else $error("denominator not a power of two");

	// a missing fraction gives denominator one
	a_zero_frac: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && o_num == '0 |-> o_den == DenW'(1))
		else $error("zero numerator with denominator other than one");

	// a reduced fraction has an odd numerator below its denominator
	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && o_num != '0 |-> o_num[0] && ({1'b0, o_num} < o_den))
		else $error("fraction not reduced");

	// infinities and NaN carry no magnitude
	a_special: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && o_cls != CLASS_FINITE |-> o_int == '0 && o_num == '0)
		else $error("special class with nonzero magnitude");

endmodule

bind half_float_to_mixed_fraction_core hfmf_checker u_hfmf_checker (.*);
